/* rtl/core/crb_pkg.sv */
`timescale 1ns / 1ps

package crb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_TERMS = 16;
    localparam int IDX_W     = $clog2(MAX_TERMS);
    localparam int CNT_W     = 5;
    localparam int INV_W     = 31;
    localparam int DATA_W    = 32;
    localparam int ONE       = 1 << FRAC_BITS;

    // x spans [0, ONE]; raw terms keep headroom for floor drift
    localparam int XW = FRAC_BITS + 1;
    localparam int TW = FRAC_BITS + 6;
    // |dT_n/dr| grows like n^2 * inv_span
    localparam int DW = INV_W + 2 * $clog2(MAX_TERMS) + 3;

    localparam logic signed [DATA_W-1:0] LOWER_BOUND_RESET = 32'sd0;
    localparam logic signed [DATA_W-1:0] UPPER_BOUND_RESET = 32'sd327680;
    localparam logic [INV_W-1:0]         INV_SPAN_RESET    = 31'd13107;
    localparam logic [CNT_W-1:0]         TERM_COUNT_RESET  = 5'd8;
    localparam logic                     POSITIVE_RESET    = 1'b0;

    typedef enum logic [2:0] {
        REG_LOWER_BOUND   = 3'd0,
        REG_UPPER_BOUND   = 3'd1,
        REG_INV_SPAN      = 3'd2,
        REG_TERM_COUNT    = 3'd3,
        REG_POSITIVE_MODE = 3'd4
    } crb_reg_t;

    typedef struct packed {
        logic [INV_W-1:0] inv_span;
        logic [CNT_W-1:0] term_count;
        logic             positive_mode;
    } crb_cfg_t;

    typedef struct packed {
        logic [XW-1:0] x;
        logic          outside;
    } crb_front_t;

    typedef struct packed {
        logic [IDX_W-1:0]         term_index;
        logic signed [DATA_W-1:0] term_value;
        logic signed [DATA_W-1:0] term_derivative;
        logic                     last_term;
        logic                     out_of_range;
        logic                     saturated;
    } crb_term_t;

endpackage

/* rtl/core/crb_cfg_if.sv */
`timescale 1ns / 1ps

interface crb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/crb_dist_if.sv */
`timescale 1ns / 1ps

interface crb_dist_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] distance;

    modport source (output valid, distance, input ready);
    modport sink (input valid, distance, output ready);
endinterface

/* rtl/core/crb_term_if.sv */
`timescale 1ns / 1ps

interface crb_term_if;
    logic               valid;
    logic               ready;
    logic [3:0]         term_index;
    logic signed [31:0] term_value;
    logic signed [31:0] term_derivative;
    logic               last_term;
    logic               out_of_range;
    logic               saturated;

    modport source (output valid, term_index, term_value, term_derivative, last_term,
                    out_of_range, saturated, input ready);
    modport sink (input valid, term_index, term_value, term_derivative, last_term,
                  out_of_range, saturated, output ready);
endinterface

/* rtl/core/chebyshev_radial_basis.sv */
// a distance passes s1, s2, s3, generator state, raw term reg and output reg
// throughput: one term per cycle while result.ready holds, set by the
// one-step-per-cycle recurrence loop in the term generator that feeds the single
// result port; a distance yields min(term_count, 16) terms, none for a zero term_count
// reset: configuration registers return to their default values and all stages empty
`timescale 1ns / 1ps

module chebyshev_radial_basis import crb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    crb_cfg_if.sink    cfg,
    crb_dist_if.sink   sample,
    crb_term_if.source result
);

    localparam int PROD_W = DATA_W + INV_W;
    localparam int PX_W   = PROD_W - FRAC_BITS;

    logic signed [DATA_W-1:0] lower_bound_reg;
    logic signed [DATA_W-1:0] upper_bound_reg;
    logic [INV_W-1:0]         inv_span_reg;
    logic [CNT_W-1:0]         term_count_reg;
    logic                     positive_mode_reg;

    logic                     s1_valid_reg;
    logic [DATA_W-1:0]        s1_dist_reg;
    logic                     s1_outside_reg;
    logic                     s2_valid_reg;
    logic [PROD_W-1:0]        s2_prod_reg;
    logic                     s2_outside_reg;
    logic                     s3_valid_reg;
    crb_front_t               s3_reg;
    logic                     out_valid_reg;
    crb_term_t                out_reg;

    logic                     s1_free;
    logic                     s2_free;
    logic                     s3_free;
    logic                     out_free;
    logic [DATA_W-1:0]        s1_dist_next;
    logic                     s1_outside_next;
    logic [PX_W-1:0]          px;
    crb_front_t               s3_next;
    crb_cfg_t                 gen_cfg;
    logic                     gen_ready;
    logic                     gen_valid;
    crb_term_t                gen_term;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_bound_reg   <= LOWER_BOUND_RESET;
            upper_bound_reg   <= UPPER_BOUND_RESET;
            inv_span_reg      <= INV_SPAN_RESET;
            term_count_reg    <= TERM_COUNT_RESET;
            positive_mode_reg <= POSITIVE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_LOWER_BOUND:   lower_bound_reg   <= cfg.data;
                REG_UPPER_BOUND:   upper_bound_reg   <= cfg.data;
                REG_INV_SPAN:      inv_span_reg      <= cfg.data[INV_W-1:0];
                REG_TERM_COUNT:    term_count_reg    <= cfg.data[CNT_W-1:0];
                REG_POSITIVE_MODE: positive_mode_reg <= cfg.data[0];
                default:           ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || result.ready;
    assign s3_free  = !s3_valid_reg || gen_ready;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;

    assign sample.ready = s1_free;

    // r - lower is exact in 32 bits whenever r lies at or above lower
    assign s1_dist_next    = DATA_W'(sample.distance - lower_bound_reg);
    assign s1_outside_next = (sample.distance < lower_bound_reg)
                          || (sample.distance > upper_bound_reg);

    assign px = s2_prod_reg[PROD_W-1:FRAC_BITS];

    always_comb
    begin
        s3_next.outside = s2_outside_reg;
        if (px > PX_W'(ONE))
        begin
            s3_next.x = XW'(ONE);
        end
        else
        begin
            s3_next.x = px[XW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= gen_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && sample.valid)
        begin
            s1_dist_reg    <= s1_dist_next;
            s1_outside_reg <= s1_outside_next;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_prod_reg    <= PROD_W'(s1_dist_reg) * PROD_W'(inv_span_reg);
            s2_outside_reg <= s1_outside_reg;
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
        if (out_free && gen_valid)
        begin
            out_reg <= gen_term;
        end
    end

    assign gen_cfg.inv_span      = inv_span_reg;
    assign gen_cfg.term_count    = term_count_reg;
    assign gen_cfg.positive_mode = positive_mode_reg;

    crb_term_gen u_term_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (gen_cfg),
        .in_valid  (s3_valid_reg),
        .in_ready  (gen_ready),
        .in_data   (s3_reg),
        .out_valid (gen_valid),
        .out_ready (out_free),
        .out_data  (gen_term)
    );

    assign result.valid           = out_valid_reg;
    assign result.term_index      = out_reg.term_index;
    assign result.term_value      = out_reg.term_value;
    assign result.term_derivative = out_reg.term_derivative;
    assign result.last_term       = out_reg.last_term;
    assign result.out_of_range    = out_reg.out_of_range;
    assign result.saturated       = out_reg.saturated;

endmodule

/* rtl/core/crb_term_gen.sv */
`timescale 1ns / 1ps

module crb_term_gen import crb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  crb_cfg_t   cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  crb_front_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output crb_term_t  out_data
);

    localparam int PXT_W = XW + 1 + TW;
    localparam int PIT_W = INV_W + 1 + TW;
    localparam int PXD_W = XW + 1 + DW;
    localparam int TC_W  = PXT_W + 1;
    localparam int DC_W  = PXD_W + 2;
    localparam int TP_W  = TW + 1;
    localparam int DP_W  = DW + 1;

    // recurrence state
    logic                 busy_reg;
    logic [IDX_W-1:0]     n_reg;
    logic [XW-1:0]        x_reg;
    logic                 outside_reg;
    logic signed [TW-1:0] t1_reg;
    logic signed [TW-1:0] t2_reg;
    logic signed [DW-1:0] d1_reg;
    logic signed [DW-1:0] d2_reg;

    // raw term register ahead of output formatting
    logic                 pv_reg;
    logic [IDX_W-1:0]     p_n_reg;
    logic signed [TW-1:0] p_t_reg;
    logic signed [DW-1:0] p_d_reg;
    logic                 p_last_reg;
    logic                 p_outside_reg;

    logic                    post_free;
    logic                    step;
    logic                    last_n;
    logic                    load;
    logic [IDX_W-1:0]        count_m1;
    logic                    count_zero;
    logic signed [XW:0]      x_s;
    logic signed [INV_W:0]   inv_s;
    logic signed [PXT_W-1:0] prod_xt;
    logic signed [PIT_W-1:0] prod_it;
    logic signed [PXD_W-1:0] prod_xd;
    logic signed [TC_W-1:0]  t_calc;
    logic signed [DC_W-1:0]  d_calc;
    logic signed [TW-1:0]    t_next;
    logic signed [DW-1:0]    d_next;
    logic signed [TP_W-1:0]  pos_t;
    logic signed [DP_W-1:0]  sel_d;
    logic [DP_W-32:0]        d_hi;
    logic                    d_fits;

    always_comb
    begin
        if (cfg.term_count > CNT_W'(MAX_TERMS))
        begin
            count_m1 = IDX_W'(MAX_TERMS - 1);
        end
        else
        begin
            count_m1 = IDX_W'(cfg.term_count - 1'b1);
        end
    end

    assign count_zero = (cfg.term_count == '0);
    assign post_free  = !pv_reg || out_ready;
    assign step       = busy_reg && post_free;
    assign last_n     = (n_reg == count_m1);
    assign in_ready   = !busy_reg || (step && last_n);
    assign load       = in_valid && in_ready && !count_zero;

    assign x_s   = {1'b0, x_reg};
    assign inv_s = {1'b0, cfg.inv_span};

    // T_n = 2*M(x,T1) - T2, D_n = 2*M(inv,T1) + 2*M(x,D1) - D2
    always_comb
    begin
        prod_xt = PXT_W'(x_s) * PXT_W'(t1_reg);
        prod_it = PIT_W'(inv_s) * PIT_W'(t1_reg);
        prod_xd = PXD_W'(x_s) * PXD_W'(d1_reg);
        t_calc  = (TC_W'(prod_xt >>> FRAC_BITS) <<< 1) - TC_W'(t2_reg);
        d_calc  = (DC_W'(prod_it >>> FRAC_BITS) <<< 1)
                + (DC_W'(prod_xd >>> FRAC_BITS) <<< 1)
                - DC_W'(d2_reg);
    end

    always_comb
    begin
        priority if (n_reg == IDX_W'(0))
        begin
            t_next = TW'(ONE);
            d_next = '0;
        end
        else if (n_reg == IDX_W'(1))
        begin
            t_next = TW'(x_reg);
            d_next = DW'(cfg.inv_span);
        end
        else
        begin
            t_next = t_calc[TW-1:0];
            d_next = d_calc[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pv_reg   <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
            end
            else if (step && last_n)
            begin
                busy_reg <= 1'b0;
            end
            if (post_free)
            begin
                pv_reg <= step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            n_reg       <= '0;
            x_reg       <= in_data.x;
            outside_reg <= in_data.outside;
        end
        else if (step)
        begin
            n_reg <= n_reg + 1'b1;
        end
        if (step)
        begin
            t2_reg        <= t1_reg;
            t1_reg        <= t_next;
            d2_reg        <= d1_reg;
            d1_reg        <= d_next;
            p_n_reg       <= n_reg;
            p_t_reg       <= t_next;
            p_d_reg       <= d_next;
            p_last_reg    <= last_n;
            p_outside_reg <= outside_reg;
        end
    end

    // output formatting: shifted form, derivative clip, zeroed terms when out of range
    always_comb
    begin
        pos_t = TP_W'(ONE) - TP_W'(p_t_reg);
        if (cfg.positive_mode && (p_n_reg != '0))
        begin
            sel_d = (-DP_W'(p_d_reg)) >>> 1;
        end
        else
        begin
            sel_d = DP_W'(p_d_reg);
        end
        d_hi   = sel_d[DP_W-1:31];
        d_fits = (&d_hi) || !(|d_hi);

        out_data.term_index   = p_n_reg;
        out_data.last_term    = p_last_reg;
        out_data.out_of_range = p_outside_reg;
        if (p_outside_reg)
        begin
            out_data.term_value      = '0;
            out_data.term_derivative = '0;
            out_data.saturated       = 1'b0;
        end
        else
        begin
            if (cfg.positive_mode && (p_n_reg != '0))
            begin
                out_data.term_value = DATA_W'(pos_t >>> 1);
            end
            else
            begin
                out_data.term_value = DATA_W'(p_t_reg);
            end
            if (d_fits)
            begin
                out_data.term_derivative = sel_d[DATA_W-1:0];
            end
            else if (sel_d[DP_W-1])
            begin
                out_data.term_derivative = 32'sh8000_0000;
            end
            else
            begin
                out_data.term_derivative = 32'sh7FFF_FFFF;
            end
            out_data.saturated = !d_fits;
        end
    end

    assign out_valid = pv_reg;

endmodule

/* rtl/core/crb_checker.sv */
`timescale 1ns / 1ps

module crb_checker import crb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [31:0] cfg_data,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  term_index,
    input logic [31:0] term_value,
    input logic        last_term,
    input logic        out_of_range
);

    logic             in_fire;
    logic             out_fire;
    logic [CNT_W-1:0] count_reg;
    logic [3:0]       pending_reg;
    logic [3:0]       pending_next;
    logic [3:0]       exp_idx_reg;
    logic             prev_oor_reg;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // distances still owed a final term
    always_comb
    begin
        pending_next = pending_reg;
        if (in_fire && (count_reg != '0))
        begin
            pending_next = pending_next + 1'b1;
        end
        if (out_fire && last_term)
        begin
            pending_next = pending_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= TERM_COUNT_RESET;
            pending_reg  <= '0;
            exp_idx_reg  <= '0;
            prev_oor_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && (cfg_index == REG_TERM_COUNT))
            begin
                count_reg <= cfg_data[CNT_W-1:0];
            end
            pending_reg <= pending_next;
            if (out_fire)
            begin
                exp_idx_reg  <= last_term ? 4'd0 : term_index + 1'b1;
                prev_oor_reg <= out_of_range;
            end
        end
    end

    a_index_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> term_index == exp_idx_reg)
        else $error("term index out of sequence");

    a_range_flag_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && (exp_idx_reg != 4'd0) |-> out_of_range == prev_oor_reg)
        else $error("out_of_range changed within one distance");

    a_no_orphan_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && last_term |-> pending_reg != 4'd0)
        else $error("final term without an accepted distance");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(term_index) && $stable(term_value))
        else $error("result changed while stalled");

endmodule

bind chebyshev_radial_basis crb_checker u_crb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .in_valid     (sample.valid),
    .in_ready     (sample.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .term_index   (result.term_index),
    .term_value   (result.term_value),
    .last_term    (result.last_term),
    .out_of_range (result.out_of_range)
);
